/* rtl/ocp_pkg.sv */
// package: types, constants and arithmetic helpers for the octagon corner point block
package ocp_pkg;

    localparam int COORD_W     = 32;
    localparam int NUM_EDGES   = 4;
    localparam int EDGE_W      = $clog2(NUM_EDGES);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // edge order within one box
    localparam logic [EDGE_W-1:0] EDGE_TOP    = EDGE_W'(0);
    localparam logic [EDGE_W-1:0] EDGE_BOTTOM = EDGE_W'(1);
    localparam logic [EDGE_W-1:0] EDGE_RIGHT  = EDGE_W'(2);
    localparam logic [EDGE_W-1:0] EDGE_LEFT   = EDGE_W'(3);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COORD_W:0]   t_wide;

    localparam t_coord COORD_MAX = t_coord'({1'b0, {(COORD_W-1){1'b1}}});
    localparam t_coord COORD_MIN = t_coord'({1'b1, {(COORD_W-1){1'b0}}});

    typedef struct packed {
        t_coord min_x;
        t_coord max_x;
        t_coord min_y;
        t_coord max_y;
        t_coord min_z;
        t_coord max_z;
        t_coord min_diag_sum;
        t_coord max_diag_sum;
        t_coord min_diag_diff;
        t_coord max_diag_diff;
    } t_box;

    // one edge: either the diagonal vertex alone or two clamped endpoints
    typedef struct packed {
        logic   single;
        t_coord x0;
        t_coord y0;
        t_coord x1;
        t_coord y1;
    } t_edge;

    typedef struct packed {
        t_edge [NUM_EDGES-1:0] edges;
        t_coord                max_z;
        t_coord                min_z;
    } t_job;

    function automatic t_wide add_w(t_coord a, t_coord b);
        return t_wide'({a[COORD_W-1], a}) + t_wide'({b[COORD_W-1], b});
    endfunction

    function automatic t_wide sub_w(t_coord a, t_coord b);
        return t_wide'({a[COORD_W-1], a}) - t_wide'({b[COORD_W-1], b});
    endfunction

    // floor halving: always fits the coordinate width
    function automatic t_coord half(t_wide v);
        return t_coord'(v[COORD_W:1]);
    endfunction

    function automatic t_coord sat(t_wide v);
        if (v[COORD_W] != v[COORD_W-1]) begin
            return v[COORD_W] ? COORD_MIN : COORD_MAX;
        end
        return t_coord'(v[COORD_W-1:0]);
    endfunction

    function automatic t_coord clamp_lo(t_wide v, t_coord b);
        t_wide bw;
        bw = t_wide'({b[COORD_W-1], b});
        if (v < bw) begin
            return b;
        end
        return sat(v);
    endfunction

    function automatic t_coord clamp_hi(t_wide v, t_coord b);
        t_wide bw;
        bw = t_wide'({b[COORD_W-1], b});
        if (v > bw) begin
            return b;
        end
        return sat(v);
    endfunction

endpackage

/* rtl/ocp_box_if.sv */
// interface: box input channel
interface ocp_box_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  min_x;
    logic signed [31:0]  max_x;
    logic signed [31:0]  min_y;
    logic signed [31:0]  max_y;
    logic signed [31:0]  min_z;
    logic signed [31:0]  max_z;
    logic signed [31:0]  min_diag_sum;
    logic signed [31:0]  max_diag_sum;
    logic signed [31:0]  min_diag_diff;
    logic signed [31:0]  max_diag_diff;

    modport source (
        output valid, min_x, max_x, min_y, max_y, min_z, max_z,
               min_diag_sum, max_diag_sum, min_diag_diff, max_diag_diff,
        input  ready
    );
    modport sink (
        input  valid, min_x, max_x, min_y, max_y, min_z, max_z,
               min_diag_sum, max_diag_sum, min_diag_diff, max_diag_diff,
        output ready
    );
endinterface

/* rtl/ocp_point_if.sv */
// interface: corner point output channel
interface ocp_point_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  point_x;
    logic signed [31:0]  point_y;
    logic signed [31:0]  point_z;
    logic                last_point;

    modport source (
        output valid, point_x, point_y, point_z, last_point,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, last_point,
        output ready
    );
endinterface

/* rtl/octagon_box_corner_points.sv */
// Octagon box corner points: each accepted box gives 8 to 16 corner points, one per cycle on
// the output channel while it is ready, two points (max z then min z) per xy corner; an edge
// whose diagonal vertex lies inside its bound gives one xy corner, otherwise two clamped
// endpoints. Points come from the single point sequencer in the back end. From input to
// first point a box passes the box register, the edge classification into a two-entry job
// queue, and the output register. Boxes are taken on consecutive cycles while the queue has
// room, so the front end runs ahead of the output by up to three boxes.
module octagon_box_corner_points (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ocp_box_if.sink     i_box,
    ocp_point_if.source o_point
);

    logic          w_job_vld;
    ocp_pkg::t_job w_job;
    logic          w_q_rdy;
    logic          w_q_vld;
    ocp_pkg::t_job w_q_job;
    logic          w_pop;

    ocp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_box     (i_box),
        .o_job_vld (w_job_vld),
        .o_job     (w_job),
        .i_job_rdy (w_q_rdy)
    );

    ocp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_vld),
        .i_data  (w_job),
        .o_rdy   (w_q_rdy),
        .o_vld   (w_q_vld),
        .o_data  (w_q_job),
        .i_pop   (w_pop)
    );

    ocp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job_vld (w_q_vld),
        .i_job     (w_q_job),
        .o_job_pop (w_pop),
        .o_point   (o_point)
    );

`ifndef SYNTH
    // a job leaves the queue exactly when its final point is loaded
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_point.valid && o_point.last_point)
        else $error("job popped without a final point");

    // an accepted box is held in the front end on the next cycle
    a_box_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_box.valid && i_box.ready |=> w_job_vld)
        else $error("accepted box lost in front end");

    // front end keeps its job while the queue is full
    a_front_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_vld && !w_q_rdy |=> w_job_vld && $stable(w_job))
        else $error("front end job changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_point.valid)
        else $error("output word valid after reset");
`endif

endmodule

/* rtl/ocp_front.sv */
// front end: registers a box and classifies its top, bottom, right and left edges into a job word
module ocp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ocp_box_if.sink       i_box,
    output logic          o_job_vld,
    output ocp_pkg::t_job o_job,
    input  logic          i_job_rdy
);

    logic          r_vld;
    ocp_pkg::t_box r_box;
    logic          w_take;

    assign i_box.ready = !r_vld || i_job_rdy;
    assign w_take      = i_box.valid && i_box.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_take) begin
            r_vld <= 1'b1;
        end else if (i_job_rdy) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_box.min_x         <= i_box.min_x;
            r_box.max_x         <= i_box.max_x;
            r_box.min_y         <= i_box.min_y;
            r_box.max_y         <= i_box.max_y;
            r_box.min_z         <= i_box.min_z;
            r_box.max_z         <= i_box.max_z;
            r_box.min_diag_sum  <= i_box.min_diag_sum;
            r_box.max_diag_sum  <= i_box.max_diag_sum;
            r_box.min_diag_diff <= i_box.min_diag_diff;
            r_box.max_diag_diff <= i_box.max_diag_diff;
        end
    end

    always_comb begin
        ocp_pkg::t_coord t_top;
        ocp_pkg::t_coord t_bot;
        ocp_pkg::t_coord t_rgt;
        ocp_pkg::t_coord t_lft;
        ocp_pkg::t_edge  e_top;
        ocp_pkg::t_edge  e_bot;
        ocp_pkg::t_edge  e_rgt;
        ocp_pkg::t_edge  e_lft;

        // top edge, y = max_y
        t_top        = ocp_pkg::half(ocp_pkg::add_w(r_box.max_diag_sum, r_box.max_diag_diff));
        e_top.single = (t_top <= r_box.max_y);
        if (e_top.single) begin
            e_top.x0 = ocp_pkg::half(ocp_pkg::sub_w(r_box.max_diag_sum, r_box.max_diag_diff));
            e_top.y0 = t_top;
        end else begin
            e_top.x0 = ocp_pkg::clamp_lo(ocp_pkg::sub_w(r_box.max_y, r_box.max_diag_diff),
                                         r_box.min_x);
            e_top.y0 = r_box.max_y;
        end
        e_top.x1 = ocp_pkg::clamp_hi(ocp_pkg::sub_w(r_box.max_diag_sum, r_box.max_y),
                                     r_box.max_x);
        e_top.y1 = r_box.max_y;

        // bottom edge, y = min_y
        t_bot        = ocp_pkg::half(ocp_pkg::add_w(r_box.min_diag_sum, r_box.min_diag_diff));
        e_bot.single = (t_bot >= r_box.min_y);
        if (e_bot.single) begin
            e_bot.x0 = ocp_pkg::half(ocp_pkg::sub_w(r_box.min_diag_sum, r_box.min_diag_diff));
            e_bot.y0 = t_bot;
        end else begin
            e_bot.x0 = ocp_pkg::clamp_lo(ocp_pkg::sub_w(r_box.min_diag_sum, r_box.min_y),
                                         r_box.min_x);
            e_bot.y0 = r_box.min_y;
        end
        e_bot.x1 = ocp_pkg::clamp_hi(ocp_pkg::sub_w(r_box.min_y, r_box.min_diag_diff),
                                     r_box.max_x);
        e_bot.y1 = r_box.min_y;

        // right edge, x = max_x
        t_rgt        = ocp_pkg::half(ocp_pkg::sub_w(r_box.max_diag_sum, r_box.min_diag_diff));
        e_rgt.single = (t_rgt <= r_box.max_x);
        if (e_rgt.single) begin
            e_rgt.x0 = t_rgt;
            e_rgt.y0 = ocp_pkg::half(ocp_pkg::add_w(r_box.max_diag_sum, r_box.min_diag_diff));
        end else begin
            e_rgt.x0 = r_box.max_x;
            e_rgt.y0 = ocp_pkg::clamp_lo(ocp_pkg::add_w(r_box.max_x, r_box.min_diag_diff),
                                         r_box.min_y);
        end
        e_rgt.x1 = r_box.max_x;
        e_rgt.y1 = ocp_pkg::clamp_hi(ocp_pkg::sub_w(r_box.max_diag_sum, r_box.max_x),
                                     r_box.max_y);

        // left edge, x = min_x
        t_lft        = ocp_pkg::half(ocp_pkg::sub_w(r_box.min_diag_sum, r_box.max_diag_diff));
        e_lft.single = (t_lft >= r_box.min_x);
        if (e_lft.single) begin
            e_lft.x0 = t_lft;
            e_lft.y0 = ocp_pkg::half(ocp_pkg::add_w(r_box.min_diag_sum, r_box.max_diag_diff));
        end else begin
            e_lft.x0 = r_box.min_x;
            e_lft.y0 = ocp_pkg::clamp_lo(ocp_pkg::sub_w(r_box.min_diag_sum, r_box.min_x),
                                         r_box.min_y);
        end
        e_lft.x1 = r_box.min_x;
        e_lft.y1 = ocp_pkg::clamp_hi(ocp_pkg::add_w(r_box.max_diag_diff, r_box.min_x),
                                     r_box.max_y);

        o_job.edges[ocp_pkg::EDGE_TOP]    = e_top;
        o_job.edges[ocp_pkg::EDGE_BOTTOM] = e_bot;
        o_job.edges[ocp_pkg::EDGE_RIGHT]  = e_rgt;
        o_job.edges[ocp_pkg::EDGE_LEFT]   = e_lft;
        o_job.max_z = r_box.max_z;
        o_job.min_z = r_box.min_z;
    end

    assign o_job_vld = r_vld;

endmodule

/* rtl/ocp_queue.sv */
// job queue between the front end and the point sequencer
module ocp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ocp_pkg::t_job i_data,
    output logic          o_rdy,
    output logic          o_vld,
    output ocp_pkg::t_job o_data,
    input  logic          i_pop
);

    ocp_pkg::t_job                 r_mem [ocp_pkg::QUEUE_DEPTH];
    logic [ocp_pkg::QPTR_W-1:0]    r_wr;
    logic [ocp_pkg::QPTR_W-1:0]    r_rd;
    logic [ocp_pkg::QCNT_W-1:0]    r_cnt;
    logic                          w_wr;
    logic                          w_rd;

    assign o_rdy  = (r_cnt != ocp_pkg::QCNT_W'(ocp_pkg::QUEUE_DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_data = r_mem[r_rd];
    assign w_wr   = i_push && o_rdy;
    assign w_rd   = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                if (r_wr == ocp_pkg::QPTR_W'(ocp_pkg::QUEUE_DEPTH - 1)) begin
                    r_wr <= '0;
                end else begin
                    r_wr <= r_wr + ocp_pkg::QPTR_W'(1);
                end
            end
            if (w_rd) begin
                if (r_rd == ocp_pkg::QPTR_W'(ocp_pkg::QUEUE_DEPTH - 1)) begin
                    r_rd <= '0;
                end else begin
                    r_rd <= r_rd + ocp_pkg::QPTR_W'(1);
                end
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + ocp_pkg::QCNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - ocp_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

/* rtl/ocp_back.sv */
// back end: walks the edges of the head job and sends one corner point per word
module ocp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_vld,
    input  ocp_pkg::t_job i_job,
    output logic          o_job_pop,
    ocp_point_if.source   o_point
);

    logic [ocp_pkg::EDGE_W-1:0] r_edge;
    logic                       r_pt;
    logic                       r_zlo;
    logic                       r_vld;
    ocp_pkg::t_coord            r_x;
    ocp_pkg::t_coord            r_y;
    ocp_pkg::t_coord            r_z;
    logic                       r_last;

    ocp_pkg::t_edge             w_edge;
    logic                       w_load;
    logic                       w_emit;
    logic                       w_edge_done;
    logic                       w_last;

    assign w_edge      = i_job.edges[r_edge];
    assign w_load      = !r_vld || o_point.ready;
    assign w_emit      = w_load && i_job_vld;
    assign w_edge_done = w_edge.single || r_pt;
    assign w_last      = (r_edge == ocp_pkg::EDGE_LEFT) && w_edge_done && r_zlo;
    assign o_job_pop   = w_emit && w_last;

    // sequence: edge, then endpoint, then max z before min z
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge <= '0;
            r_pt   <= 1'b0;
            r_zlo  <= 1'b0;
            r_vld  <= 1'b0;
        end else begin
            if (w_emit) begin
                r_vld <= 1'b1;
                r_zlo <= !r_zlo;
                if (r_zlo) begin
                    if (w_edge_done) begin
                        r_pt   <= 1'b0;
                        r_edge <= r_edge + ocp_pkg::EDGE_W'(1);
                    end else begin
                        r_pt   <= 1'b1;
                    end
                end
            end else if (o_point.ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_x    <= r_pt ? w_edge.x1 : w_edge.x0;
            r_y    <= r_pt ? w_edge.y1 : w_edge.y0;
            r_z    <= r_zlo ? i_job.min_z : i_job.max_z;
            r_last <= w_last;
        end
    end

    assign o_point.valid      = r_vld;
    assign o_point.point_x    = r_x;
    assign o_point.point_y    = r_y;
    assign o_point.point_z    = r_z;
    assign o_point.last_point = r_last;

endmodule
